>>> hdl/fthc_pkg.sv
// ----------------------------------------------------------------------------
// fthc_pkg
// Types, constants and helpers shared by the flow tuple hash classifier.
// ----------------------------------------------------------------------------
package fthc_pkg;

  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam int          FLOW_W     = 13;
  localparam logic [FLOW_W-1:0] FLOW_FIRST = 13'd1;
  localparam logic [FLOW_W-1:0] FLOW_MAX   = 13'd8191;
  localparam int          HASH_W     = 31;
  localparam int          NUM_VALUES = 5;
  localparam logic [2:0]  LAST_VALUE = 3'(NUM_VALUES - 1);

  typedef struct packed {
    logic [15:0] frame_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
  } in_data_t;

  typedef struct packed {
    logic [HASH_W-1:0] flow_hash;
    logic [FLOW_W-1:0] flow_number;
    logic              new_flow;
  } out_data_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_UPDATE,
    ST_EMIT
  } fthc_state_t;

  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic hash_step;
    logic mem_read;
    logic update;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_keep;
    logic hash_last;
  } dp_status_t;

  // index of the most significant non-zero nibble, zero when the word is zero
  function automatic logic [2:0] top_nibble(input logic [31:0] word);
    logic [2:0] idx;
    idx = 3'd0;
    for (int n = 1; n < 8; n++) begin
      if (word[n*4 +: 4] != 4'd0) idx = 3'(n);
    end
    return idx;
  endfunction

  // lowercase ascii hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else           c = 8'h57 + {4'd0, d};
    return c;
  endfunction

endpackage

>>> hdl/fthc_if.sv
// ----------------------------------------------------------------------------
// fthc_if
// Valid/ready channels for packet tuples in and flow results out.
// ----------------------------------------------------------------------------
interface fthc_in_if import fthc_pkg::*;;
  logic     valid;
  logic     ready;
  in_data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fthc_out_if import fthc_pkg::*;;
  logic      valid;
  logic      ready;
  out_data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/fthc_ram.sv
// ----------------------------------------------------------------------------
// fthc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fthc_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/fthc_datapath.sv
// ----------------------------------------------------------------------------
// fthc_datapath
// Tuple ordering, character-serial AP hash, flow table and result register.
// ----------------------------------------------------------------------------
module fthc_datapath import fthc_pkg::*; #(
  parameter int TABLE_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_data_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output out_data_t  out_data
);

  localparam int TABLE_DEPTH = 1 << TABLE_BITS;

  logic [31:0]           val_r [NUM_VALUES];
  logic [2:0]            nib_r;
  logic [2:0]            cnt_r;
  logic [31:0]           hash_r;
  logic [31:0]           hash_nxt;
  logic                  par_r;
  logic [TABLE_BITS-1:0] clr_r;
  logic [FLOW_W-1:0]     next_num_r;
  logic [FLOW_W-1:0]     res_num_r;
  logic                  res_new_r;
  out_data_t             out_r;

  logic                  swap;
  logic [31:0]           first_addr;
  logic [31:0]           first_port;
  logic [31:0]           second_addr;
  logic [31:0]           second_port;
  logic [3:0]            digit;
  logic [31:0]           chr;
  logic [TABLE_BITS-1:0] slot;
  logic                  ram_we;
  logic [TABLE_BITS-1:0] ram_waddr;
  logic [FLOW_W-1:0]     ram_wdata;
  logic [FLOW_W-1:0]     ram_rdata;
  logic                  rd_zero;

  // endpoint with the larger port goes first; on equal ports the source goes first
  assign swap        = in_data.src_port < in_data.dst_port;
  assign first_addr  = swap ? in_data.dst_addr : in_data.src_addr;
  assign second_addr = swap ? in_data.src_addr : in_data.dst_addr;
  assign first_port  = {16'd0, swap ? in_data.dst_port : in_data.src_port};
  assign second_port = {16'd0, swap ? in_data.src_port : in_data.dst_port};

  assign digit = val_r[0][{nib_r, 2'b00} +: 4];
  assign chr   = {24'd0, hex_char(digit)};

  always_comb begin
    if (!par_r) begin
      hash_nxt = hash_r ^ ((hash_r << 7) ^ chr ^ (hash_r >> 3));
    end else begin
      hash_nxt = hash_r ^ ~((hash_r << 11) ^ chr ^ (hash_r >> 5));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      val_r[0] <= first_addr;
      val_r[1] <= first_port;
      val_r[2] <= second_addr;
      val_r[3] <= second_port;
      val_r[4] <= {24'd0, in_data.protocol};
      nib_r    <= top_nibble(first_addr);
      cnt_r    <= 3'd0;
      hash_r   <= 32'd0;
      par_r    <= 1'b0;
    end else if (cmd.hash_step) begin
      hash_r <= hash_nxt;
      par_r  <= ~par_r;
      if (nib_r == 3'd0) begin
        for (int i = 0; i < NUM_VALUES - 1; i++) begin
          val_r[i] <= val_r[i+1];
        end
        nib_r <= top_nibble(val_r[1]);
        cnt_r <= cnt_r + 3'd1;
      end else begin
        nib_r <= nib_r - 3'd1;
      end
    end
  end

  assign slot = hash_r[TABLE_BITS-1:0];

  // flow table, cleared one entry at a time after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      next_num_r <= FLOW_FIRST;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.update && rd_zero && next_num_r != FLOW_MAX) begin
        next_num_r <= next_num_r + 1'b1;
      end
    end
  end

  assign rd_zero   = ram_rdata == '0;
  assign ram_we    = cmd.clr_step | (cmd.update & rd_zero);
  assign ram_waddr = cmd.clr_step ? clr_r : slot;
  assign ram_wdata = cmd.clr_step ? '0 : next_num_r;

  fthc_ram #(
    .WIDTH (FLOW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.mem_read),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_num_r <= rd_zero ? next_num_r : ram_rdata;
      res_new_r <= rd_zero;
    end
    if (cmd.load_out) begin
      out_r.flow_hash   <= hash_r[HASH_W-1:0];
      out_r.flow_number <= res_num_r;
      out_r.new_flow    <= res_new_r;
    end
  end

  assign out_data = out_r;

  assign status.clr_done  = &clr_r;
  assign status.in_keep   = (in_data.frame_type == ETH_IPV4) &&
                            (in_data.protocol == PROTO_TCP || in_data.protocol == PROTO_UDP);
  assign status.hash_last = (nib_r == 3'd0) && (cnt_r == LAST_VALUE);

endmodule

>>> hdl/fthc_ctrl.sv
// ----------------------------------------------------------------------------
// fthc_ctrl
// Sequencer for table clear, hashing, table update and result hand-off.
// ----------------------------------------------------------------------------
module fthc_ctrl import fthc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  fthc_state_t state_r;
  fthc_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        in_fire;
  logic        out_free;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (status.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_fire && status.in_keep) state_nxt = ST_HASH;
      ST_HASH:   if (status.hash_last) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR:  cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_fire;
      end
      ST_HASH:   cmd.hash_step = 1'b1;
      ST_READ:   cmd.mem_read = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_EMIT:   cmd.load_out = out_free;
      default:   cmd = '0;
    endcase
  end

  // result register stays full until the sink takes the item
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/flow_tuple_hash_classifier.sv
// ----------------------------------------------------------------------------
// flow_tuple_hash_classifier
// Hashes the ordered IPv4 TCP/UDP five-tuple and numbers flows per table slot.
//
//   channel   dir  payload                                   handshake
//   in_chan   in   frame_type, addrs, ports, protocol        valid/ready
//   out_chan  out  flow_hash, flow_number, new_flow          valid/ready
//
// An item is taken while idle; after a dropped item the block stays idle.
// A kept item is then hashed one hex character per cycle (5 to 26 characters),
// followed by a table read, an update and a hand-off, one item at a time.
// After reset the table is cleared one slot a cycle with the input not ready.
// A waiting result does not block the input; the next item's result holds
// until the output register is free.
// ----------------------------------------------------------------------------
module flow_tuple_hash_classifier import fthc_pkg::*; #(
  parameter int TABLE_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  fthc_in_if.sink           in_chan,
  fthc_out_if.source        out_chan
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fthc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  fthc_datapath #(
    .TABLE_BITS (TABLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_chan.data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_chan.data)
  );

endmodule
